// ===== sv/bsau_pkg.sv =====
`timescale 1ns / 1ps

package bsau_pkg;

    localparam int SET_WIDTH  = 32;
    localparam int LANE_W     = 8;
    localparam int LANES      = (SET_WIDTH + LANE_W - 1) / LANE_W;
    localparam int PAD_W      = LANES * LANE_W;
    localparam int LANE_CNT_W = $clog2(LANE_W + 1);
    localparam int CNT_W      = $clog2(SET_WIDTH + 1);
    localparam int CMD_W      = 4;
    localparam int COUNT_W    = 6;
    localparam int STAGES     = 4;

    // s_tdata: command, set_a, set_b, zero pad
    localparam int IN_BITS    = CMD_W + 2 * SET_WIDTH;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    // m_tdata: result_set, result_flag, element_count, zero pad
    localparam int OUT_BITS   = SET_WIDTH + 1 + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_EMPTY      = 4'd0,
        CMD_NONEMPTY   = 4'd1,
        CMD_DISJOINT   = 4'd2,
        CMD_OVERLAP    = 4'd3,
        CMD_EQUAL      = 4'd4,
        CMD_SUBSET     = 4'd5,
        CMD_UNION      = 4'd6,
        CMD_INTERSECT  = 4'd7,
        CMD_XOR        = 4'd8,
        CMD_DIFF       = 4'd9,
        CMD_COMPLEMENT = 4'd10,
        CMD_COUNT      = 4'd11,
        CMD_LT         = 4'd12,
        CMD_LE         = 4'd13,
        CMD_GE         = 4'd14,
        CMD_GT         = 4'd15
    } cmd_t;

    typedef logic [SET_WIDTH-1:0] set_t;

    // per-stage load strobes from the handshake control to the datapath
    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

    function automatic logic [LANE_CNT_W-1:0] lane_pop(input logic [LANE_W-1:0] x);
        logic [LANE_CNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < LANE_W; k++) begin
            n = n + LANE_CNT_W'(x[k]);
        end
        return n;
    endfunction

endpackage

// ===== sv/bsau_datapath.sv =====
`timescale 1ns / 1ps

module bsau_datapath
    import bsau_pkg::*;
(
    input  logic         aclk,
    input  pipe_ctrl_t   ctrl,
    input  cmd_t         command,
    input  set_t         set_a,
    input  set_t         set_b,
    output set_t         result_set,
    output logic         result_flag,
    output logic [COUNT_W-1:0] element_count
);

    // stage 1: registered operands
    cmd_t cmd1_reg;
    set_t a1_reg, b1_reg;

    // stage 2: bitwise results, predicates, word compare, lane counts
    cmd_t cmd2_reg, cmd2_next;
    set_t rs2_reg, rs2_next;
    logic pfl2_reg, pfl2_next;
    logic wlt2_reg, wlt2_next;
    logic weq2_reg, weq2_next;
    logic [LANE_CNT_W-1:0] popa2_reg [LANES];
    logic [LANE_CNT_W-1:0] popb2_reg [LANES];
    logic [LANE_CNT_W-1:0] popa2_next [LANES];
    logic [LANE_CNT_W-1:0] popb2_next [LANES];

    // stage 3: full cardinalities
    cmd_t cmd3_reg;
    set_t rs3_reg;
    logic pfl3_reg, wlt3_reg, weq3_reg;
    logic [CNT_W-1:0] cnta3_reg, cntb3_reg, cnta3_next, cntb3_next;

    // stage 4: output fields
    set_t rs4_reg, rs4_next;
    logic fl4_reg, fl4_next;
    logic [COUNT_W-1:0] cnt4_reg, cnt4_next;

    logic [PAD_W-1:0] a_pad, b_pad;
    logic ord_lt, ord_eq;

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            cmd1_reg <= command;
            a1_reg   <= set_a;
            b1_reg   <= set_b;
        end
    end

    always_comb begin
        a_pad = PAD_W'(a1_reg);
        b_pad = PAD_W'(b1_reg);
        for (int i = 0; i < LANES; i++) begin
            popa2_next[i] = lane_pop(a_pad[i*LANE_W +: LANE_W]);
            popb2_next[i] = lane_pop(b_pad[i*LANE_W +: LANE_W]);
        end
        cmd2_next = cmd1_reg;
        wlt2_next = $signed(a1_reg) < $signed(b1_reg);
        weq2_next = a1_reg == b1_reg;
        rs2_next  = '0;
        pfl2_next = 1'b0;
        case (cmd1_reg)
            CMD_EMPTY:      pfl2_next = a1_reg == '0;
            CMD_NONEMPTY:   pfl2_next = a1_reg != '0;
            CMD_DISJOINT:   pfl2_next = (a1_reg & b1_reg) == '0;
            CMD_OVERLAP:    pfl2_next = (a1_reg & b1_reg) != '0;
            CMD_EQUAL:      pfl2_next = a1_reg == b1_reg;
            CMD_SUBSET:     pfl2_next = (a1_reg & ~b1_reg) == '0;
            CMD_UNION:      rs2_next  = a1_reg | b1_reg;
            CMD_INTERSECT:  rs2_next  = a1_reg & b1_reg;
            CMD_XOR:        rs2_next  = a1_reg ^ b1_reg;
            CMD_DIFF:       rs2_next  = a1_reg & ~b1_reg;
            CMD_COMPLEMENT: rs2_next  = ~a1_reg;
            default:        rs2_next  = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            cmd2_reg  <= cmd2_next;
            rs2_reg   <= rs2_next;
            pfl2_reg  <= pfl2_next;
            wlt2_reg  <= wlt2_next;
            weq2_reg  <= weq2_next;
            popa2_reg <= popa2_next;
            popb2_reg <= popb2_next;
        end
    end

    always_comb begin
        cnta3_next = '0;
        cntb3_next = '0;
        for (int i = 0; i < LANES; i++) begin
            cnta3_next = cnta3_next + CNT_W'(popa2_reg[i]);
            cntb3_next = cntb3_next + CNT_W'(popb2_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            cmd3_reg  <= cmd2_reg;
            rs3_reg   <= rs2_reg;
            pfl3_reg  <= pfl2_reg;
            wlt3_reg  <= wlt2_reg;
            weq3_reg  <= weq2_reg;
            cnta3_reg <= cnta3_next;
            cntb3_reg <= cntb3_next;
        end
    end

    // cardinality first, signed word compare breaks ties
    assign ord_lt = (cnta3_reg < cntb3_reg) || ((cnta3_reg == cntb3_reg) && wlt3_reg);
    assign ord_eq = (cnta3_reg == cntb3_reg) && weq3_reg;

    always_comb begin
        rs4_next  = rs3_reg;
        fl4_next  = pfl3_reg;
        cnt4_next = '0;
        case (cmd3_reg)
            CMD_COUNT: cnt4_next = COUNT_W'(cnta3_reg);
            CMD_LT:    fl4_next  = ord_lt;
            CMD_LE:    fl4_next  = ord_lt | ord_eq;
            CMD_GE:    fl4_next  = ~ord_lt;
            CMD_GT:    fl4_next  = ~(ord_lt | ord_eq);
            default:   cnt4_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            rs4_reg  <= rs4_next;
            fl4_reg  <= fl4_next;
            cnt4_reg <= cnt4_next;
        end
    end

    assign result_set    = rs4_reg;
    assign result_flag   = fl4_reg;
    assign element_count = cnt4_reg;

endmodule

// ===== sv/bitset_set_algebra_unit.sv =====
`timescale 1ns / 1ps

// Set-algebra unit on 32-element sets held as words (bit k set: element k present).
// Each beat carries a command and two sets and produces exactly one result beat with
// a result set, a flag and an element count; fields a command does not use read zero.
// The pipeline has four register stages (operand register, bitwise ops with lane
// popcounts and word compare, cardinality sum, final select). When nothing stalls, a
// beat's result is offered on the output once it reaches the final select register, and
// one beat is taken every cycle. Each stage holds its own beat under backpressure and
// keeps filling bubbles, so input is still taken while a finished result waits on the
// output, until every stage holds a beat.

module bitset_set_algebra_unit
    import bsau_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command [3:0], set_a [35:4], set_b [67:36], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_set [31:0], result_flag [32], element_count [38:33], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] ready;
    pipe_ctrl_t ctrl;

    set_t result_set;
    logic result_flag;
    logic [COUNT_W-1:0] element_count;

    // a stage may load when it is empty or its beat moves on this cycle
    always_comb begin
        ready[STAGES-1] = ~valid_reg[STAGES-1] | m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            ready[k] = ~valid_reg[k] | ready[k+1];
        end
        ctrl.load = ready;
        valid_next = valid_reg;
        if (ready[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (ready[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    bsau_datapath u_datapath (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .command       (cmd_t'(s_tdata[CMD_W-1:0])),
        .set_a         (s_tdata[CMD_W +: SET_WIDTH]),
        .set_b         (s_tdata[CMD_W + SET_WIDTH +: SET_WIDTH]),
        .result_set    (result_set),
        .result_flag   (result_flag),
        .element_count (element_count)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = OUT_DATA_W'({element_count, result_flag, result_set});

endmodule

// ===== sv/bsau_checker.sv =====
`timescale 1ns / 1ps

module bsau_checker
    import bsau_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a held result beat stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an empty output stage means the whole pipeline can take a beat
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    // a nonzero count only comes with the count command, which leaves set and flag zero
    a_count_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[SET_WIDTH+1 +: COUNT_W] != '0) |-> (m_tdata[SET_WIDTH:0] == '0))
        else $error("count beat carries set or flag");

    a_flag_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SET_WIDTH] |->
            (m_tdata[SET_WIDTH-1:0] == '0) && (m_tdata[SET_WIDTH+1 +: COUNT_W] == '0))
        else $error("flag beat carries set or count");

endmodule

bind bitset_set_algebra_unit bsau_checker u_bsau_checker (.*);

// ===== dv/bitset_set_algebra_unit_test.sv =====
`timescale 1ns / 1ps

module bitset_set_algebra_unit_test;
    import bsau_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 850;
    localparam int DRAIN_CYCLES  = 4 * STAGES;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AFTER    = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        set_t               members;
        logic               flag;
        logic [COUNT_W-1:0] card;
    } answer_t;

    typedef struct packed {
        cmd_t    op;
        set_t    a;
        set_t    b;
        answer_t want;
    } pending_t;

    typedef struct packed {
        cmd_t    op;
        set_t    a;
        set_t    b;
        logic    pinned;
        answer_t want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // command, set_a, set_b, zero pad
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // result_set, result_flag, element_count, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;

    pending_t  pending_answers[$];
    stim_row_t directed_rows[DIRECTED_ROWS];
    int        mismatch_count = 0;
    int        beats_accepted = 0;
    int        cycle_count = 0;
    int        sender_idle_pct = 0;
    int        receiver_idle_pct = 0;
    bit        hold_done = 1'b0;

    bitset_set_algebra_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic int member_count(set_t s);
        int n;
        n = 0;
        for (int k = 0; k < SET_WIDTH; k++) begin
            n += int'(s[k]);
        end
        return n;
    endfunction

    // cardinality first, ties broken by a signed compare of the words
    function automatic int set_order(set_t a, set_t b);
        int ca;
        int cb;
        ca = member_count(a);
        cb = member_count(b);
        if (ca != cb) begin
            return (ca < cb) ? -1 : 1;
        end
        if (a == b) begin
            return 0;
        end
        return ($signed(a) < $signed(b)) ? -1 : 1;
    endfunction

    function automatic answer_t set_algebra_answer(cmd_t op, set_t a, set_t b);
        answer_t ans;
        int      order;
        ans   = '0;
        order = set_order(a, b);
        case (op)
            CMD_EMPTY:      ans.flag = (a == '0);
            CMD_NONEMPTY:   ans.flag = (a != '0);
            CMD_DISJOINT:   ans.flag = ((a & b) == '0);
            CMD_OVERLAP:    ans.flag = ((a & b) != '0);
            CMD_EQUAL:      ans.flag = (a == b);
            CMD_SUBSET:     ans.flag = ((a | b) == b);
            CMD_UNION:      ans.members = a | b;
            CMD_INTERSECT:  ans.members = a & b;
            CMD_XOR:        ans.members = a ^ b;
            CMD_DIFF:       ans.members = a & ~b;
            CMD_COMPLEMENT: ans.members = ~a;
            CMD_COUNT:      ans.card = COUNT_W'(member_count(a));
            CMD_LT:         ans.flag = (order < 0);
            CMD_LE:         ans.flag = (order <= 0);
            CMD_GE:         ans.flag = (order >= 0);
            default:        ans.flag = (order > 0);
        endcase
        return ans;
    endfunction

    function automatic set_t random_set();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return set_t'(1) << $urandom_range(0, SET_WIDTH - 1);
            3: return $urandom & $urandom & $urandom;
            4: return $urandom | $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // second operand related to the first, so that subset, equality and
    // cardinality ties come up often
    function automatic set_t partner_set(set_t a);
        int sh;
        sh = $urandom_range(1, SET_WIDTH - 1);
        case ($urandom_range(0, 5))
            0: return a;
            1: return a & $urandom;
            2: return a | $urandom;
            3: return (a << sh) | (a >> (SET_WIDTH - sh));
            4: return ~a;
            default: return random_set();
        endcase
    endfunction

    task automatic offer_beat(cmd_t op, set_t a, set_t b, logic pinned, answer_t want);
        pending_t entry;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({b, a, op});
        do @(posedge aclk); while (!s_tready);
        entry.op   = op;
        entry.a    = a;
        entry.b    = b;
        entry.want = pinned ? want : set_algebra_answer(op, a, b);
        pending_answers.push_back(entry);
        beats_accepted++;
        @(negedge aclk);
    endtask

    task automatic check_result();
        pending_t entry;
        answer_t  got;
        got.members = m_tdata[SET_WIDTH-1:0];
        got.flag    = m_tdata[SET_WIDTH];
        got.card    = m_tdata[SET_WIDTH+1 +: COUNT_W];
        if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("unexpected result beat: set %h flag %b count %0d",
                         got.members, got.flag, got.card);
            end
        end else begin
            entry = pending_answers.pop_front();
            if (got !== entry.want) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("mismatch %s a=%h b=%h: ",
                             entry.op.name(), entry.a, entry.b,
                             "want set %h flag %b count %0d, ",
                             entry.want.members, entry.want.flag, entry.want.card,
                             "got set %h flag %b count %0d",
                             got.members, got.flag, got.card);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result();
        end
    end

    // receiver: random backpressure plus one long hold-off while the sender keeps going
    initial begin
        forever begin
            @(negedge aclk);
            if (!hold_done && beats_accepted >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("bitset_set_algebra_unit_test failed");
        $finish;
    end

    initial begin
        cmd_t op;
        set_t a;
        set_t b;

        directed_rows = '{
            '{CMD_EMPTY,      32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_EMPTY,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0}},
            '{CMD_NONEMPTY,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 6'd0}},
            '{CMD_NONEMPTY,   32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_DISJOINT,   32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_OVERLAP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_EQUAL,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_SUBSET,     32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_SUBSET,     32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0}},
            '{CMD_UNION,      32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
              '{32'hFFFF_FFFF, 1'b0, 6'd0}},
            '{CMD_INTERSECT,  32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
              '{32'h1234_5678, 1'b0, 6'd0}},
            '{CMD_XOR,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 6'd0}},
            '{CMD_DIFF,       32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              '{32'hFFFF_FFFF, 1'b0, 6'd0}},
            // second operand must not leak into the complement
            '{CMD_COMPLEMENT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
              '{32'hFFFF_FFFF, 1'b0, 6'd0}},
            '{CMD_COMPLEMENT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0}},
            '{CMD_COUNT,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd32}},
            '{CMD_COUNT,      32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 6'd0}},
            // equal cardinality, sign bit decides
            '{CMD_LT,         32'h0000_0001, 32'h8000_0000, 1'b0, '0},
            '{CMD_LT,         32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 6'd0}},
            '{CMD_LE,         32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_GE,         32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{CMD_GT,         32'h8000_0000, 32'h0000_0001, 1'b0, '0},
            '{CMD_GT,         32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 6'd0}},
            '{CMD_COUNT,      32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, '0}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        sender_idle_pct   = 32;
        receiver_idle_pct = 79;
        foreach (directed_rows[i]) begin
            offer_beat(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                       directed_rows[i].pinned, directed_rows[i].want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                sender_idle_pct   = 79;
                receiver_idle_pct = 32;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            op = cmd_t'($urandom_range(0, 15));
            a  = random_set();
            b  = partner_set(a);
            offer_beat(op, a, b, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("bitset_set_algebra_unit_test passed");
        end else begin
            $display("bitset_set_algebra_unit_test failed");
        end
        $finish;
    end

endmodule

// ===== bitset_set_algebra_unit.f =====
sv/bsau_pkg.sv
sv/bsau_datapath.sv
sv/bitset_set_algebra_unit.sv
sv/bsau_checker.sv
dv/bitset_set_algebra_unit_test.sv
